@@ hdl/ssgh_pkg.sv @@
package ssgh_pkg;

  // Fixed-point format of every word on the ports.
  localparam int W     = 32;
  localparam int F     = 16;
  localparam int THW   = 16;
  localparam int DW    = W + 1;          // node difference, signed
  localparam int SQW   = 2 * W;          // one squared component or product
  localparam int SW    = 2 * W + 2;      // sum of three squares
  localparam int RTW   = W + 1;          // integer square root of the sum
  localparam int TW    = SW + 2;         // square root trial value
  localparam int PROJ  = ((122 - 2 * W) > 62) ? 62 : (122 - 2 * W);
  localparam int PW    = PROJ + 1;       // projector quotient bits
  localparam int PNW   = SW + PROJ + 1;  // projector dividend
  localparam int NW    = 2 * W + 1;      // dividend of the divide by length
  localparam int QW    = W;              // quotient bits of the divide by length
  localparam int LRRW  = RTW + W;        // length times inverse rest length
  localparam int VW    = LRRW + 1 - F;   // rounded length ratio
  localparam int HSW   = PW + W + 1;     // projector times inverse rest length
  localparam int NL    = 9;              // lanes of the divide by length
  localparam int NH    = 6;              // unique Hessian entries
  localparam logic [THW-1:0] THR_RESET = THW'(1);

  typedef logic [W-1:0] word_t;

  localparam word_t MAXPOS = {1'b0, {(W - 1){1'b1}}};
  localparam word_t MINNEG = {1'b1, {(W - 1){1'b0}}};

  // Item traveling beside the square root pipeline.
  typedef struct packed {
    logic                      valid;
    logic [SW-1:0]             s;
    logic [NH-1:0][SW-1:0]     nm;
    logic [2:0][W-1:0]         ad;
    logic [2:0]                neg;
    word_t                     r;
    logic                      last;
  } isq_side_t;

  // Item inside the projector divider.
  typedef struct packed {
    logic                      valid;
    logic [SW-1:0]             s;
    logic [RTW-1:0]            lr;
    logic [LRRW-1:0]           lrr;
    logic [2:0][SQW-1:0]       gnum;
    logic [2:0]                neg;
    word_t                     r;
    logic                      last;
    logic [NH-1:0][SW-1:0]     prem;
    logic [NH-1:0][PW-1:0]     pq;
  } pdiv_t;

  typedef struct packed {
    logic                      valid;
    logic [RTW-1:0]            lr;
    logic [VW-1:0]             emag;
    logic                      eneg;
    logic [NH-1:0][SQW-1:0]    plo;
    logic [NH-1:0][PW-1:0]     phi;
    logic [2:0][NW-1:0]        gnum;
    logic [2:0]                neg;
    logic                      last;
  } prod_t;

  typedef struct packed {
    logic                      valid;
    logic [RTW-1:0]            lr;
    logic                      zeroed;
    logic                      lrz;
    word_t                     strain;
    logic [NH-1:0][NW-1:0]     hnum;
    logic [2:0][NW-1:0]        gnum;
    logic [2:0]                neg;
    logic                      last;
  } hnum_t;

  typedef struct packed {
    logic                      valid;
    word_t                     strain;
    logic                      zeroed;
    logic                      lrz;
    logic [2:0]                neg;
    logic                      last;
  } fin_side_t;

  // One restoring step of the six projector divisions, all by the same sum.
  function automatic pdiv_t pdiv_step(pdiv_t x);
    pdiv_t         y;
    logic [SW:0]   t;
    y = x;
    for (int k = 0; k < NH; k++) begin
      t = {x.prem[k], x.pq[k][PW-1]};
      if (t >= {1'b0, x.s}) begin
        y.prem[k] = SW'(t - {1'b0, x.s});
        y.pq[k]   = {x.pq[k][PW-2:0], 1'b1};
      end else begin
        y.prem[k] = t[SW-1:0];
        y.pq[k]   = {x.pq[k][PW-2:0], 1'b0};
      end
    end
    return y;
  endfunction

  function automatic word_t sat_word(logic [QW-1:0] q, logic ovf, logic neg);
    word_t y;
    if (neg) begin
      if (ovf || (W'(q) > MINNEG)) y = MINNEG;
      else                         y = ~W'(q) + W'(1);
    end else begin
      if (ovf || (W'(q) > MAXPOS)) y = MAXPOS;
      else                         y = W'(q);
    end
    return y;
  endfunction

endpackage

@@ hdl/ssgh_isqrt.sv @@
module ssgh_isqrt (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [ssgh_pkg::SW-1:0]    s_i,
  output logic [ssgh_pkg::RTW-1:0]   root_o
);

  localparam int SW  = ssgh_pkg::SW;
  localparam int RTW = ssgh_pkg::RTW;
  localparam int TW  = ssgh_pkg::TW;

  logic [SW-1:0]  rem_q  [RTW];
  logic [RTW-1:0] root_q [RTW];

  // One result bit per stage, most significant first.
  for (genvar k = 0; k < RTW; k++) begin : g_step
    localparam int B = RTW - 1 - k;
    logic [SW-1:0]  rem_in;
    logic [RTW-1:0] root_in;
    logic [TW-1:0]  trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign rem_in  = s_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // (root + 2^B)^2 - root^2, with the bits at and below B still clear.
    assign trial = (TW'(root_in) << (B + 1)) + (TW'(1) << (2 * B));
    assign ge    = TW'(rem_in) >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? SW'(TW'(rem_in) - trial) : rem_in;
        root_q[k] <= root_in | (RTW'(ge) << B);
      end
    end
  end

  assign root_o = root_q[RTW-1];

endmodule

@@ hdl/ssgh_div_lr.sv @@
module ssgh_div_lr (
  input  logic                                        clk_i,
  input  logic                                        en_i,
  input  logic [ssgh_pkg::RTW-1:0]                    lr_i,
  input  logic [ssgh_pkg::NL-1:0][ssgh_pkg::NW-1:0]   num_i,
  output logic [ssgh_pkg::NL-1:0][ssgh_pkg::QW-1:0]   q_o,
  output logic [ssgh_pkg::NL-1:0]                     ovf_o
);

  localparam int RTW = ssgh_pkg::RTW;
  localparam int NW  = ssgh_pkg::NW;
  localparam int QW  = ssgh_pkg::QW;
  localparam int NL  = ssgh_pkg::NL;

  logic [RTW-1:0]               lr_q  [QW];
  logic [NL-1:0][RTW-1:0]       rem_q [QW+1];
  logic [NL-1:0][QW-1:0]        qb_q  [QW+1];
  logic [NL-1:0]                ovf_q [QW+1];

  // A quotient that needs more than QW bits is flagged here and saturates later.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lr_q[0] <= lr_i;
      for (int j = 0; j < NL; j++) begin
        ovf_q[0][j] <= num_i[j] >= (NW'(lr_i) << QW);
        rem_q[0][j] <= num_i[j][NW-1:QW];
        qb_q[0][j]  <= num_i[j][QW-1:0];
      end
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [NL-1:0][RTW-1:0] rem_d;
    logic [NL-1:0][QW-1:0]  qb_d;

    always_comb begin
      logic [RTW:0] t;
      for (int j = 0; j < NL; j++) begin
        t = {rem_q[k-1][j], qb_q[k-1][j][QW-1]};
        if (t >= {1'b0, lr_q[k-1]}) begin
          rem_d[j] = RTW'(t - {1'b0, lr_q[k-1]});
          qb_d[j]  = {qb_q[k-1][j][QW-2:0], 1'b1};
        end else begin
          rem_d[j] = t[RTW-1:0];
          qb_d[j]  = {qb_q[k-1][j][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        qb_q[k]  <= qb_d;
        ovf_q[k] <= ovf_q[k-1];
      end
    end

    if (k < QW) begin : g_lr
      always_ff @(posedge clk_i) begin
        if (en_i) lr_q[k] <= lr_q[k-1];
      end
    end
  end

  assign q_o   = qb_q[QW];
  assign ovf_o = ovf_q[QW];

endmodule

@@ hdl/spring_strain_grad_hess.sv @@
// Stretch strain, strain gradient and strain Hessian block of one spring.
// Slave stream: tdata carries node0 x/y/z, node1 x/y/z and the inverse rest
// length, 32 bits each in that order from bit 0; tlast marks the last spring
// of a batch. Master stream: tdata carries strain, gradient x/y/z and the
// Hessian entries xx, xy, xz, yy, yz, zz, 32 bits each from bit 0; tuser is
// set when the Hessian block was forced to zero; tlast copies the input mark.
// The strain threshold register is written through cfg_we_i / cfg_wdata_i
// and resets to one raw unit.
// One item is accepted per cycle while the pipeline is not held. A result passes
// through 3 stages of differences and squares, 33 square root stages,
// 1 product stage, 59 projector divide stages, 2 stages of products and
// rounding, 33 stages of the nine-lane divide by length and the output
// register. The square root and the two dividers make up most of these stages.
// All stages move together; while the receiver holds tready low with a result
// waiting, the whole pipeline holds and s_axis_tready_o is low. Reset empties
// the pipeline.
module spring_strain_grad_hess (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,       // eps_threshold
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // node0_x, node0_y, node0_z, node1_x, node1_y, node1_z, inv_ref_len
  input  logic [223:0] s_axis_tdata_i,
  input  logic         s_axis_tlast_i,    // last_spring
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // strain, grad_x, grad_y, grad_z, hess_xx, hess_xy, hess_xz, hess_yy,
  // hess_yz, hess_zz
  output logic [319:0] m_axis_tdata_o,
  output logic         m_axis_tuser_o,    // hess_zeroed
  output logic         m_axis_tlast_o     // last_out
);

  localparam int W    = ssgh_pkg::W;
  localparam int F    = ssgh_pkg::F;
  localparam int DW   = ssgh_pkg::DW;
  localparam int SQW  = ssgh_pkg::SQW;
  localparam int SW   = ssgh_pkg::SW;
  localparam int RTW  = ssgh_pkg::RTW;
  localparam int PROJ = ssgh_pkg::PROJ;
  localparam int PW   = ssgh_pkg::PW;
  localparam int PNW  = ssgh_pkg::PNW;
  localparam int NW   = ssgh_pkg::NW;
  localparam int QW   = ssgh_pkg::QW;
  localparam int LRRW = ssgh_pkg::LRRW;
  localparam int VW   = ssgh_pkg::VW;
  localparam int HSW  = ssgh_pkg::HSW;
  localparam int NL   = ssgh_pkg::NL;
  localparam int NH   = ssgh_pkg::NH;
  localparam int THW  = ssgh_pkg::THW;

  logic                       en;
  logic [THW-1:0]             thr_q;

  logic                       v1_q;
  logic [2:0]                 neg1_q;
  logic [2:0][W-1:0]          ad1_q;
  ssgh_pkg::word_t            r1_q;
  logic                       last1_q;

  logic                       v2_q;
  logic [2:0]                 neg2_q;
  logic [2:0][W-1:0]          ad2_q;
  logic [2:0][SQW-1:0]        sq2_q;
  logic [2:0][SQW-1:0]        pr2_q;
  ssgh_pkg::word_t            r2_q;
  logic                       last2_q;

  ssgh_pkg::isq_side_t        s3_q;
  ssgh_pkg::isq_side_t        isd_q [RTW];
  logic [RTW-1:0]             root;
  ssgh_pkg::pdiv_t            e1_d, e1_q;
  ssgh_pkg::pdiv_t            pd_q [PW];
  ssgh_pkg::prod_t            e2_d, e2_q;
  ssgh_pkg::hnum_t            e3_d, e3_q;
  ssgh_pkg::fin_side_t        fd_q [QW+1];

  logic [NL-1:0][NW-1:0]      div_num;
  logic [NL-1:0][QW-1:0]      div_q;
  logic [NL-1:0]              div_ovf;

  logic [2:0]                 neg1_d;
  logic [2:0][W-1:0]          ad1_d;
  logic [2:0][SQW-1:0]        sq2_d;
  logic [2:0][SQW-1:0]        pr2_d;
  ssgh_pkg::isq_side_t        s3_d;
  logic                       pq_ok;

  logic                       out_valid_q;
  logic [319:0]               out_data_d, out_data_q;
  logic                       out_zeroed_q;
  logic                       out_last_q;

  // The pipeline advances unless a finished result is waiting and tready is low.
  assign en              = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ssgh_pkg::THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // Stage 1: edge vector, magnitude and sign of each component.
  always_comb begin
    logic [DW-1:0] d;
    logic [DW-1:0] nd;
    for (int i = 0; i < 3; i++) begin
      d         = {s_axis_tdata_i[(3+i)*W + W - 1], s_axis_tdata_i[(3+i)*W +: W]}
                - {s_axis_tdata_i[i*W + W - 1], s_axis_tdata_i[i*W +: W]};
      nd        = -d;
      neg1_d[i] = d[DW-1];
      ad1_d[i]  = d[DW-1] ? nd[W-1:0] : d[W-1:0];
    end
  end

  // Stage 2: squares and cross products.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq2_d[i] = SQW'(ad1_q[i]) * SQW'(ad1_q[i]);
    end
    pr2_d[0] = SQW'(ad1_q[0]) * SQW'(ad1_q[1]);
    pr2_d[1] = SQW'(ad1_q[0]) * SQW'(ad1_q[2]);
    pr2_d[2] = SQW'(ad1_q[1]) * SQW'(ad1_q[2]);
  end

  // Stage 3: squared length and numerators of the projector entries.
  // A diagonal numerator is the sum of the other two squares.
  always_comb begin
    s3_d.valid = v2_q;
    s3_d.s     = SW'(sq2_q[0]) + SW'(sq2_q[1]) + SW'(sq2_q[2]);
    s3_d.nm[0] = SW'(sq2_q[1]) + SW'(sq2_q[2]);
    s3_d.nm[1] = SW'(pr2_q[0]);
    s3_d.nm[2] = SW'(pr2_q[1]);
    s3_d.nm[3] = SW'(sq2_q[0]) + SW'(sq2_q[2]);
    s3_d.nm[4] = SW'(pr2_q[2]);
    s3_d.nm[5] = SW'(sq2_q[0]) + SW'(sq2_q[1]);
    s3_d.ad    = ad2_q;
    s3_d.neg   = neg2_q;
    s3_d.r     = r2_q;
    s3_d.last  = last2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      s3_q <= '0;
    end else if (en) begin
      v1_q <= s_axis_tvalid_i;
      v2_q <= v1_q;
      s3_q <= s3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg1_q  <= neg1_d;
      ad1_q   <= ad1_d;
      r1_q    <= s_axis_tdata_i[6*W +: W];
      last1_q <= s_axis_tlast_i;
      neg2_q  <= neg1_q;
      ad2_q   <= ad1_q;
      sq2_q   <= sq2_d;
      pr2_q   <= pr2_d;
      r2_q    <= r1_q;
      last2_q <= last1_q;
    end
  end

  ssgh_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .s_i    (s3_q.s),
    .root_o (root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < RTW; k++) isd_q[k] <= '0;
    end else if (en) begin
      isd_q[0] <= s3_q;
      for (int k = 1; k < RTW; k++) isd_q[k] <= isd_q[k-1];
    end
  end

  // Product stage: length ratio, gradient numerators, rounded projector dividends.
  always_comb begin
    logic [PNW-1:0] pn;
    e1_d       = '0;
    e1_d.valid = isd_q[RTW-1].valid;
    e1_d.s     = isd_q[RTW-1].s;
    e1_d.lr    = root;
    e1_d.lrr   = LRRW'(root) * LRRW'(isd_q[RTW-1].r);
    e1_d.neg   = isd_q[RTW-1].neg;
    e1_d.r     = isd_q[RTW-1].r;
    e1_d.last  = isd_q[RTW-1].last;
    for (int i = 0; i < 3; i++) begin
      e1_d.gnum[i] = SQW'(isd_q[RTW-1].ad[i]) * SQW'(isd_q[RTW-1].r);
    end
    for (int k = 0; k < NH; k++) begin
      pn           = (PNW'(isd_q[RTW-1].nm[k]) << PROJ) + PNW'(isd_q[RTW-1].s >> 1);
      e1_d.prem[k] = pn[PNW-1:PW];
      e1_d.pq[k]   = pn[PW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_q <= '0;
      for (int k = 0; k < PW; k++) pd_q[k] <= '0;
    end else if (en) begin
      e1_q    <= e1_d;
      pd_q[0] <= ssgh_pkg::pdiv_step(e1_q);
      for (int k = 1; k < PW; k++) pd_q[k] <= ssgh_pkg::pdiv_step(pd_q[k-1]);
    end
  end

  // Strain magnitude, split projector products, rounded gradient dividends.
  always_comb begin
    logic [LRRW:0] vsum;
    logic [VW-1:0] v;
    vsum       = {1'b0, pd_q[PW-1].lrr} + (LRRW + 1)'(1 << (F - 1));
    v          = vsum[LRRW:F];
    e2_d.valid = pd_q[PW-1].valid;
    e2_d.lr    = pd_q[PW-1].lr;
    if (v >= (VW'(1) << F)) begin
      e2_d.emag = v - (VW'(1) << F);
      e2_d.eneg = 1'b0;
    end else begin
      e2_d.emag = (VW'(1) << F) - v;
      e2_d.eneg = 1'b1;
    end
    for (int k = 0; k < NH; k++) begin
      e2_d.plo[k] = SQW'(pd_q[PW-1].pq[k][W-1:0]) * SQW'(pd_q[PW-1].r);
      e2_d.phi[k] = PW'(pd_q[PW-1].pq[k][PW-1:W]) * PW'(pd_q[PW-1].r);
    end
    for (int i = 0; i < 3; i++) begin
      e2_d.gnum[i] = NW'(pd_q[PW-1].gnum[i]) + NW'(pd_q[PW-1].lr >> 1);
    end
    e2_d.neg  = pd_q[PW-1].neg;
    e2_d.last = pd_q[PW-1].last;
  end

  // Hessian dividends after the fixed part of the length scaling, strain
  // saturation and the zeroing decision.
  always_comb begin
    logic [HSW-1:0] hs;
    e3_d.valid  = e2_q.valid;
    e3_d.lr     = e2_q.lr;
    e3_d.lrz    = e2_q.lr == '0;
    e3_d.zeroed = (e2_q.lr == '0) || (e2_q.emag <= VW'(thr_q));
    if (e2_q.eneg) begin
      if (e2_q.emag > VW'(ssgh_pkg::MINNEG)) e3_d.strain = ssgh_pkg::MINNEG;
      else                                   e3_d.strain = ~e2_q.emag[W-1:0] + W'(1);
    end else begin
      if (e2_q.emag > VW'(ssgh_pkg::MAXPOS)) e3_d.strain = ssgh_pkg::MAXPOS;
      else                                   e3_d.strain = e2_q.emag[W-1:0];
    end
    for (int k = 0; k < NH; k++) begin
      hs           = (HSW'(e2_q.phi[k]) << W) + HSW'(e2_q.plo[k])
                   + (HSW'(e2_q.lr) << (PROJ - F - 1));
      e3_d.hnum[k] = NW'(hs >> (PROJ - F));
    end
    e3_d.gnum = e2_q.gnum;
    e3_d.neg  = e2_q.neg;
    e3_d.last = e2_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e2_q <= '0;
      e3_q <= '0;
    end else if (en) begin
      e2_q <= e2_d;
      e3_q <= e3_d;
    end
  end

  // Lanes 0 to 2 carry the gradient, lanes 3 to 8 the Hessian entries.
  always_comb begin
    for (int i = 0; i < 3; i++)  div_num[i]     = e3_q.gnum[i];
    for (int k = 0; k < NH; k++) div_num[3 + k] = e3_q.hnum[k];
  end

  ssgh_div_lr u_div_lr (
    .clk_i (clk_i),
    .en_i  (en),
    .lr_i  (e3_q.lr),
    .num_i (div_num),
    .q_o   (div_q),
    .ovf_o (div_ovf)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= QW; k++) fd_q[k] <= '0;
    end else if (en) begin
      fd_q[0].valid  <= e3_q.valid;
      fd_q[0].strain <= e3_q.strain;
      fd_q[0].zeroed <= e3_q.zeroed;
      fd_q[0].lrz    <= e3_q.lrz;
      fd_q[0].neg    <= e3_q.neg;
      fd_q[0].last   <= e3_q.last;
      for (int k = 1; k <= QW; k++) fd_q[k] <= fd_q[k-1];
    end
  end

  // Output word: saturation, sign and zeroing of every gradient and Hessian entry.
  always_comb begin
    logic [NH-1:0] hneg;
    hneg[0] = 1'b0;
    hneg[1] = fd_q[QW].neg[0] == fd_q[QW].neg[1];
    hneg[2] = fd_q[QW].neg[0] == fd_q[QW].neg[2];
    hneg[3] = 1'b0;
    hneg[4] = fd_q[QW].neg[1] == fd_q[QW].neg[2];
    hneg[5] = 1'b0;
    out_data_d       = '0;
    out_data_d[W-1:0] = fd_q[QW].strain;
    for (int i = 0; i < 3; i++) begin
      if (!fd_q[QW].lrz) begin
        out_data_d[(1 + i)*W +: W] = ssgh_pkg::sat_word(div_q[i], div_ovf[i],
                                                        fd_q[QW].neg[i]);
      end
    end
    for (int k = 0; k < NH; k++) begin
      if (!fd_q[QW].zeroed) begin
        out_data_d[(4 + k)*W +: W] = ssgh_pkg::sat_word(div_q[3 + k], div_ovf[3 + k],
                                                        hneg[k]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= fd_q[QW].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q   <= out_data_d;
      out_zeroed_q <= fd_q[QW].zeroed;
      out_last_q   <= fd_q[QW].last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_zeroed_q;
  assign m_axis_tlast_o  = out_last_q;

  // Every projector quotient stays at or below one in PROJ fraction bits.
  always_comb begin
    pq_ok = 1'b1;
    for (int k = 0; k < NH; k++) begin
      if (pd_q[PW-1].pq[k] > (PW'(1) << PROJ)) pq_ok = 1'b0;
    end
  end

  // Coincident nodes divide by a zero sum; their quotients are discarded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pd_q[PW-1].valid && (pd_q[PW-1].s != '0) |-> pq_ok)
    else $error("projector quotient out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    e3_q.valid && e3_q.lrz |-> e3_q.zeroed)
    else $error("coincident nodes without zeroed Hessian");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o[10*W-1:4*W] == '0)
    else $error("zeroed Hessian carries nonzero entries");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en && e3_q.valid |=> $stable(e3_q) && $stable(div_q))
    else $error("pipeline moved during a stall");

endmodule
